FILE: rtl/mlpbp_pkg.sv
// ----------------------------------------------------------------------------
// mlpbp_pkg
// Shared types, codes and fixed-point helpers for the backprop trainer.
// ----------------------------------------------------------------------------
package mlpbp_pkg;

    typedef logic signed [23:0] q_t;
    typedef logic signed [24:0] op_t;

    typedef struct packed {
        q_t   val;
        logic clip;
    } qres_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_H0,
        ST_H1,
        ST_HS,
        ST_HP,
        ST_MERGE,
        ST_Y,
        ST_DY,
        ST_DO,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4,
        ST_DONE
    } st_t;

    typedef struct packed {
        st_t        st;
        logic       wr_en;
        logic [1:0] wr_slot;
    } lane_ctrl_t;

    localparam logic [1:0] CMD_TRAIN  = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] SLOT_W0 = 2'd0;
    localparam logic [1:0] SLOT_W1 = 2'd1;
    localparam logic [1:0] SLOT_HB = 2'd2;
    localparam logic [1:0] SLOT_OW = 2'd3;

    localparam q_t QMAX = 24'sh7FFFFF;
    localparam q_t QMIN = 24'sh800000;

    function automatic qres_t qsat(input logic signed [33:0] v);
        qres_t r;
        if (v > 34'sd8388607)
            r = '{val: QMAX, clip: 1'b1};
        else if (v < -34'sd8388608)
            r = '{val: QMIN, clip: 1'b1};
        else
            r = '{val: v[23:0], clip: 1'b0};
        return r;
    endfunction

    // Product rounded half up to Q7.16; the arithmetic shift gives the floor.
    function automatic qres_t qmul(input op_t a, input op_t b);
        logic signed [49:0] p;
        logic signed [49:0] q;
        p = a * b;
        q = (p + 50'sd32768) >>> 16;
        return qsat(q[33:0]);
    endfunction

    function automatic qres_t qadd(input q_t a, input q_t b);
        logic signed [24:0] s;
        s = $signed({a[23], a}) + $signed({b[23], b});
        return qsat(34'(s));
    endfunction

    function automatic op_t sx(input q_t a);
        return $signed({a[23], a});
    endfunction

    function automatic op_t ux(input logic [16:0] u);
        return $signed({8'b0, u});
    endfunction

    // Sigmoid derivative y * (1 - y) in Q0.16.
    function automatic logic [16:0] dsig(input logic [16:0] y);
        logic [16:0] om;
        logic [33:0] p;
        om = 17'd65536 - y;
        p  = 34'(y) * 34'(om);
        p  = p + 34'd32768;
        return p[32:16];
    endfunction

endpackage

FILE: rtl/mlpbp_sig_rom.sv
// ----------------------------------------------------------------------------
// mlpbp_sig_rom
// Sigmoid lookup table over [-8, 8), clamped at both ends.
// ----------------------------------------------------------------------------
module mlpbp_sig_rom #(
    parameter int DEPTH = 1024
) (
    input  mlpbp_pkg::q_t x,
    output logic [16:0]   y
);
    import mlpbp_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam longint FS = 64'sd1073741824;

    // Shift-and-subtract quotient of two non-negative values below 2^48,
    // evaluated only while the table is built at elaboration.
    function automatic longint udiv(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 47; b >= 0; b--)
        begin
            r = (r <<< 1) | ((n >>> b) & 64'sd1);
            q = q <<< 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Entry value computed at elaboration: exp by series and squaring, Q30.
    function automatic logic [16:0] sig_entry(input longint n);
        longint an;
        longint u;
        longint term;
        longint sum;
        longint e;
        longint num;
        an = (n < 0) ? -n : n;
        u = (an <<< 29) / DEPTH;
        term = FS;
        sum = FS;
        for (int k = 1; k <= 20; k++)
        begin
            term = udiv((term * u) >>> 30, longint'(k));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        e = (sum < 0) ? 64'sd0 : sum;
        for (int k = 0; k < 4; k++)
        begin
            e = (e * e + FS / 2) >>> 30;
        end
        num = (n >= 0) ? FS : e;
        return 17'(udiv(64'sd65536 * num + ((FS + e) >>> 1), FS + e));
    endfunction

    logic [16:0]    rom [DEPTH];
    logic [19:0]    off;
    logic [32:0]    prod;
    logic [IW-1:0]  idx;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam logic [16:0] V = sig_entry(longint'(2 * i + 1 - DEPTH));
        assign rom[i] = V;
    end

    always_comb
    begin
        off  = 20'(x + 24'sd524288);
        prod = 33'(off) * 33'(DEPTH);
        if (x < -24'sd524288)
            idx = '0;
        else if (x >= 24'sd524288)
            idx = IW'(DEPTH - 1);
        else
            idx = prod[20 +: IW];
        y = rom[idx];
    end

endmodule

FILE: rtl/mlpbp_lane.sv
// ----------------------------------------------------------------------------
// mlpbp_lane
// One hidden unit: its weights, forward sum, delta and weight updates.
// ----------------------------------------------------------------------------
module mlpbp_lane #(
    parameter int SIG_DEPTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mlpbp_pkg::lane_ctrl_t ctrl,
    input  mlpbp_pkg::q_t         x0,
    input  mlpbp_pkg::q_t         x1,
    input  mlpbp_pkg::q_t         dout,
    input  logic [15:0]           lr,
    input  mlpbp_pkg::q_t         wdata,
    output mlpbp_pkg::q_t         prod,
    output mlpbp_pkg::q_t         w0,
    output mlpbp_pkg::q_t         w1,
    output mlpbp_pkg::q_t         hb,
    output mlpbp_pkg::q_t         ow,
    output logic                  clip
);
    import mlpbp_pkg::*;

    q_t          w0_reg, w1_reg, hb_reg, ow_reg;
    q_t          acc_reg, prod_reg, t1_reg, ohd_reg, dh_reg, xd0_reg, xd1_reg;
    logic [16:0] hid_reg, dsh_reg, sig_y;
    logic        clip_reg;
    qres_t       m0, m1, m2, m3, a0, a1;
    op_t         lr_op;

    mlpbp_sig_rom #(.DEPTH(SIG_DEPTH)) u_rom (.x(acc_reg), .y(sig_y));

    assign lr_op = $signed({9'b0, lr});

    always_comb
    begin
        m0 = '0;
        m1 = '0;
        m2 = '0;
        m3 = '0;
        a0 = '0;
        a1 = '0;
        case (ctrl.st)
            ST_H0:
            begin
                m0 = qmul(sx(x0), sx(w0_reg));
                a0 = qadd(hb_reg, m0.val);
            end
            ST_H1:
            begin
                m0 = qmul(sx(x1), sx(w1_reg));
                a0 = qadd(acc_reg, m0.val);
            end
            ST_HP: m0 = qmul(ux(hid_reg), sx(ow_reg));
            ST_L1:
            begin
                m0 = qmul(sx(dout), sx(ow_reg));
                m1 = qmul(ux(hid_reg), sx(dout));
            end
            ST_L2: m0 = qmul(sx(t1_reg), ux(dsh_reg));
            ST_L3:
            begin
                m0 = qmul(sx(ohd_reg), lr_op);
                m1 = qmul(sx(dh_reg), lr_op);
                m2 = qmul(sx(x0), sx(dh_reg));
                m3 = qmul(sx(x1), sx(dh_reg));
                a0 = qadd(ow_reg, m0.val);
                a1 = qadd(hb_reg, m1.val);
            end
            ST_L4:
            begin
                m0 = qmul(sx(xd0_reg), lr_op);
                m1 = qmul(sx(xd1_reg), lr_op);
                a0 = qadd(w0_reg, m0.val);
                a1 = qadd(w1_reg, m1.val);
            end
            default: m0 = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg   <= '0;
            w1_reg   <= '0;
            hb_reg   <= '0;
            ow_reg   <= '0;
            acc_reg  <= '0;
            prod_reg <= '0;
            t1_reg   <= '0;
            ohd_reg  <= '0;
            dh_reg   <= '0;
            xd0_reg  <= '0;
            xd1_reg  <= '0;
            hid_reg  <= '0;
            dsh_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                case (ctrl.wr_slot)
                    SLOT_W0: w0_reg <= wdata;
                    SLOT_W1: w1_reg <= wdata;
                    SLOT_HB: hb_reg <= wdata;
                    SLOT_OW: ow_reg <= wdata;
                    default: w0_reg <= w0_reg;
                endcase
            end
            case (ctrl.st)
                ST_H0:
                begin
                    acc_reg  <= a0.val;
                    clip_reg <= m0.clip | a0.clip;
                end
                ST_H1:
                begin
                    acc_reg  <= a0.val;
                    clip_reg <= clip_reg | m0.clip | a0.clip;
                end
                ST_HS: hid_reg <= sig_y;
                ST_HP:
                begin
                    prod_reg <= m0.val;
                    dsh_reg  <= dsig(hid_reg);
                    clip_reg <= clip_reg | m0.clip;
                end
                ST_L1:
                begin
                    t1_reg   <= m0.val;
                    ohd_reg  <= m1.val;
                    clip_reg <= clip_reg | m0.clip | m1.clip;
                end
                ST_L2:
                begin
                    dh_reg   <= m0.val;
                    clip_reg <= clip_reg | m0.clip;
                end
                ST_L3:
                begin
                    ow_reg   <= a0.val;
                    hb_reg   <= a1.val;
                    xd0_reg  <= m2.val;
                    xd1_reg  <= m3.val;
                    clip_reg <= clip_reg | m0.clip | m1.clip | m2.clip | m3.clip
                                | a0.clip | a1.clip;
                end
                ST_L4:
                begin
                    w0_reg   <= a0.val;
                    w1_reg   <= a1.val;
                    clip_reg <= clip_reg | m0.clip | m1.clip | a0.clip | a1.clip;
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign prod = prod_reg;
    assign w0   = w0_reg;
    assign w1   = w1_reg;
    assign hb   = hb_reg;
    assign ow   = ow_reg;
    assign clip = clip_reg;

endmodule

FILE: rtl/mlp_online_backprop_step.sv
// ----------------------------------------------------------------------------
// mlp_online_backprop_step
// Online SGD trainer for a 2-input, hidden-layer, 1-output sigmoid network.
// ----------------------------------------------------------------------------
// Words enter on the in_valid/in_ready channel and each gives one result word
// on the out_valid/out_ready channel. A train word runs the forward pass,
// reports the prediction and updates every weight and bias; write and read
// words load or return one parameter. cfg_write loads the learning rate.
// Each hidden unit has its own lane that works in parallel; the output sum
// is merged one lane per cycle. The next word is accepted in the cycle after
// the result is loaded, and a train word takes longer than any other word,
// its length set by the chain of dependent multiplies and the two sigmoid
// lookups. A result waits in the output register while the receiver stalls;
// the block may take the next word meanwhile but holds its new result until
// the old one is taken. Reset clears all weights and biases to zero and sets
// the learning rate to 6554 (about 0.1).
// ----------------------------------------------------------------------------
module mlp_online_backprop_step #(
    parameter int HIDDEN_UNITS        = 2,
    parameter int SIGMOID_TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [15:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           command,
    input  mlpbp_pkg::q_t        feature_a,
    input  mlpbp_pkg::q_t        feature_b,
    input  logic [16:0]          target,
    input  logic [3:0]           param_index,
    input  mlpbp_pkg::q_t        param_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [16:0]          prediction,
    output mlpbp_pkg::q_t        read_value,
    output logic                 saturated
);
    import mlpbp_pkg::*;

    localparam int H  = HIDDEN_UNITS;
    localparam int CW = (H > 1) ? $clog2(H) : 1;

    st_t          state_reg, state_next;
    logic [15:0]  lr_reg;
    logic [1:0]   cmd_reg;
    q_t           x0_reg, x1_reg, wdata_reg, ob_reg, acco_reg, dout_reg, rd_reg;
    logic [16:0]  tgt_reg, y_reg, dy_reg, sig_y;
    logic [3:0]   idx_reg;
    logic [CW-1:0] cnt_reg;
    logic         clip_reg;
    logic         out_valid_reg;
    logic [16:0]  pred_out_reg;
    q_t           rd_out_reg;
    logic         sat_out_reg;

    lane_ctrl_t   lctrl [H];
    q_t           l_prod [H];
    q_t           l_w0 [H];
    q_t           l_w1 [H];
    q_t           l_hb [H];
    q_t           l_ow [H];
    logic [H-1:0] l_clip;

    q_t           rd_next;
    logic         is_write;
    qres_t        mg, mo, ao, md;
    logic signed [17:0] err;
    logic         done_load;

    mlpbp_sig_rom #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_rom (.x(acco_reg), .y(sig_y));

    assign is_write = (state_reg == ST_DECODE) && (cmd_reg == CMD_WRITE);

    for (genvar j = 0; j < H; j++)
    begin : g_lane
        always_comb
        begin
            lctrl[j].st      = state_reg;
            lctrl[j].wr_en   = 1'b0;
            lctrl[j].wr_slot = SLOT_W0;
            if (32'(idx_reg) == 32'(j))
            begin
                lctrl[j].wr_en   = is_write;
                lctrl[j].wr_slot = SLOT_W0;
            end
            else if (32'(idx_reg) == 32'(H + j))
            begin
                lctrl[j].wr_en   = is_write;
                lctrl[j].wr_slot = SLOT_W1;
            end
            else if (32'(idx_reg) == 32'(2 * H + j))
            begin
                lctrl[j].wr_en   = is_write;
                lctrl[j].wr_slot = SLOT_HB;
            end
            else if (32'(idx_reg) == 32'(3 * H + j))
            begin
                lctrl[j].wr_en   = is_write;
                lctrl[j].wr_slot = SLOT_OW;
            end
        end

        mlpbp_lane #(.SIG_DEPTH(SIGMOID_TABLE_DEPTH)) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lctrl[j]),
            .x0    (x0_reg),
            .x1    (x1_reg),
            .dout  (dout_reg),
            .lr    (lr_reg),
            .wdata (wdata_reg),
            .prod  (l_prod[j]),
            .w0    (l_w0[j]),
            .w1    (l_w1[j]),
            .hb    (l_hb[j]),
            .ow    (l_ow[j]),
            .clip  (l_clip[j])
        );
    end

    // Read-back select over the parameter slots.
    always_comb
    begin
        rd_next = '0;
        for (int j = 0; j < H; j++)
        begin
            if (32'(idx_reg) == 32'(j))
                rd_next = l_w0[j];
            if (32'(idx_reg) == 32'(H + j))
                rd_next = l_w1[j];
            if (32'(idx_reg) == 32'(2 * H + j))
                rd_next = l_hb[j];
            if (32'(idx_reg) == 32'(3 * H + j))
                rd_next = l_ow[j];
        end
        if (32'(idx_reg) == 32'(4 * H))
            rd_next = ob_reg;
    end

    always_comb
    begin
        mg  = qadd(acco_reg, l_prod[cnt_reg]);
        err = $signed({1'b0, tgt_reg}) - $signed({1'b0, y_reg});
        md  = qmul(25'(err), ux(dy_reg));
        mo  = qmul(sx(dout_reg), $signed({9'b0, lr_reg}));
        ao  = qadd(ob_reg, mo.val);
    end

    assign done_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE: state_next = (cmd_reg == CMD_TRAIN) ? ST_H0 : ST_DONE;
            ST_H0:     state_next = ST_H1;
            ST_H1:     state_next = ST_HS;
            ST_HS:     state_next = ST_HP;
            ST_HP:     state_next = ST_MERGE;
            ST_MERGE:
            begin
                if (cnt_reg == CW'(H - 1))
                    state_next = ST_Y;
            end
            ST_Y:      state_next = ST_DY;
            ST_DY:     state_next = ST_DO;
            ST_DO:     state_next = ST_L1;
            ST_L1:     state_next = ST_L2;
            ST_L2:     state_next = ST_L3;
            ST_L3:     state_next = ST_L4;
            ST_L4:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (done_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg        <= 16'd6554;
            ob_reg        <= '0;
            cmd_reg       <= CMD_TRAIN;
            x0_reg        <= '0;
            x1_reg        <= '0;
            wdata_reg     <= '0;
            tgt_reg       <= '0;
            idx_reg       <= '0;
            acco_reg      <= '0;
            dout_reg      <= '0;
            rd_reg        <= '0;
            y_reg         <= '0;
            dy_reg        <= '0;
            cnt_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pred_out_reg  <= '0;
            rd_out_reg    <= '0;
            sat_out_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                lr_reg <= cfg_wdata;
            // A new result loaded in the same cycle keeps out_valid high.
            if (out_valid_reg && out_ready && !done_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= command;
                        x0_reg    <= feature_a;
                        x1_reg    <= feature_b;
                        wdata_reg <= param_value;
                        idx_reg   <= param_index;
                        tgt_reg   <= (target > 17'd65536) ? 17'd65536 : target;
                    end
                end
                ST_DECODE:
                begin
                    clip_reg <= 1'b0;
                    rd_reg   <= (cmd_reg == CMD_READ) ? rd_next : '0;
                    if (is_write && (32'(idx_reg) == 32'(4 * H)))
                        ob_reg <= wdata_reg;
                end
                ST_HP:
                begin
                    acco_reg <= ob_reg;
                    cnt_reg  <= '0;
                end
                ST_MERGE:
                begin
                    acco_reg <= mg.val;
                    clip_reg <= clip_reg | mg.clip;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                ST_Y:  y_reg  <= sig_y;
                ST_DY: dy_reg <= dsig(y_reg);
                ST_DO:
                begin
                    dout_reg <= md.val;
                    clip_reg <= clip_reg | md.clip;
                end
                ST_L3:
                begin
                    ob_reg   <= ao.val;
                    clip_reg <= clip_reg | mo.clip | ao.clip;
                end
                ST_DONE:
                begin
                    if (done_load)
                    begin
                        out_valid_reg <= 1'b1;
                        rd_out_reg    <= rd_reg;
                        if (cmd_reg == CMD_TRAIN)
                        begin
                            pred_out_reg <= y_reg;
                            sat_out_reg  <= clip_reg | (|l_clip);
                        end
                        else
                        begin
                            pred_out_reg <= '0;
                            sat_out_reg  <= 1'b0;
                        end
                    end
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign prediction = pred_out_reg;
    assign read_value = rd_out_reg;
    assign saturated  = sat_out_reg;

endmodule
